// ===== rtl/mbte_pkg.sv =====
`timescale 1ns / 1ps

package mbte_pkg;

  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned MAX_CHARS   = 6;
  localparam int unsigned CNT_W       = 3;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_QP_LIMIT   = 2'd1;
  localparam logic [1:0] REG_B64_LIMIT  = 2'd2;

  localparam logic       MODE_QP        = 1'b0;
  localparam logic       MODE_B64       = 1'b1;

  localparam logic [7:0] QP_LIMIT_RST   = 8'd75;
  localparam logic [7:0] B64_LIMIT_RST  = 8'd76;

  localparam logic [7:0] CHR_EQ         = 8'd61;
  localparam logic [7:0] CHR_NL         = 8'd10;
  localparam logic [7:0] CHR_PRINT_LO   = 8'd33;
  localparam logic [7:0] CHR_PRINT_HI   = 8'd126;

  function automatic logic [7:0] hex_chr(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'd48 + {4'd0, v};
    end else begin
      r = 8'd55 + {4'd0, v};
    end
    return r;
  endfunction

  function automatic logic [7:0] b64_chr(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'd65 + {2'd0, v};
    end else if (v < 6'd52) begin
      r = 8'd71 + {2'd0, v};
    end else if (v < 6'd62) begin
      r = {2'd0, v} - 8'd4;
    end else if (v == 6'd62) begin
      r = 8'd43;
    end else begin
      r = 8'd47;
    end
    return r;
  endfunction

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [2:0] k);
    logic [8:0] s;
    s = {1'b0, a} + {6'd0, k};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

endpackage

// ===== rtl/mime_body_transfer_encoder_core.sv =====
`timescale 1ns / 1ps

// MIME body encoder: raw body bytes in, quoted-printable or base64 characters out,
// at most one character per cycle on the output stream. All characters caused by
// one byte are worked out in the accepting cycle and loaded into a six-entry
// output register that shifts out one per cycle as the receiver takes them. A
// byte makes, in quoted-printable, 1 character for a plain byte, 3 for an escape,
// 2 more with a soft break and 1 for a newline byte that hits the line limit; in
// base64, 0 for the first two bytes of a group and 4 to 6 for the third or last
// one. The next byte is taken in the cycle the last character of the previous
// one is taken, and at once when it made none. Set the mode and line limits only
// between bodies; a mode write restarts the line and the group.
module mime_body_transfer_encoder_core
  import mbte_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,   // data_byte[7:0]
  input  logic              s_axis_tlast_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [7:0]        m_axis_tdata_o,   // out_char[7:0]
  output logic              m_axis_tlast_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic             mode_q, mode_d;
  logic [7:0]       qp_lim_q, qp_lim_d;
  logic [7:0]       b64_lim_q, b64_lim_d;
  logic [15:0]      pend_b_q, pend_b_d;
  logic [1:0]       pend_cnt_q, pend_cnt_d;
  logic [7:0]       line_q, line_d;

  logic [7:0]       chr_q [MAX_CHARS];
  logic [7:0]       chr_d [MAX_CHARS];
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [7:0]       res_chr [MAX_CHARS];
  logic [CNT_W-1:0] res_cnt;
  logic [7:0]       upd_line;
  logic [15:0]      upd_pend_b;
  logic [1:0]       upd_pend_cnt;

  logic             in_acc, out_acc, cfg_wr;
  logic [7:0]       din;
  logic             esc;
  logic [1:0]       plen;
  logic [8:0]       qp_sum;
  logic             qp_over;
  logic [7:0]       piece [3];

  logic             grp_en, grp_nl;
  logic [7:0]       g_b0, g_b1, g_b2;
  logic [1:0]       g_cnt;
  logic [7:0]       g_chr [4];

  assign pready          = 1'b1;
  assign cfg_wr          = psel & penable & pwrite;
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_acc         = m_axis_tvalid_o & m_axis_tready_i;
  assign s_axis_tready_o = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && m_axis_tready_i);
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = chr_q[0];
  assign m_axis_tlast_o  = (cnt_q == CNT_W'(1));
  assign din             = s_axis_tdata_i;

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:      prdata = {{(DATA_W-1){1'b0}}, mode_q};
      REG_QP_LIMIT:  prdata = {{(DATA_W-8){1'b0}}, qp_lim_q};
      REG_B64_LIMIT: prdata = {{(DATA_W-8){1'b0}}, b64_lim_q};
      default:       prdata = '0;
    endcase
  end

  // quoted-printable piece
  assign esc      = (din < CHR_PRINT_LO) || (din == CHR_EQ) || (din > CHR_PRINT_HI);
  assign plen     = esc ? 2'd3 : 2'd1;
  assign qp_sum   = {1'b0, line_q} + {7'd0, plen};
  assign qp_over  = qp_sum > {1'b0, qp_lim_q};
  assign piece[0] = esc ? CHR_EQ : din;
  assign piece[1] = hex_chr(din[7:4]);
  assign piece[2] = hex_chr(din[3:0]);

  // base64 group: full when two bytes wait, else the partial last group at body end
  always_comb begin
    grp_en = 1'b0;
    g_b0   = pend_b_q[15:8];
    g_b1   = pend_b_q[7:0];
    g_b2   = din;
    g_cnt  = 2'd3;
    if (pend_cnt_q == 2'd2) begin
      grp_en = 1'b1;
    end else if (s_axis_tlast_i) begin
      grp_en = 1'b1;
      g_b2   = 8'd0;
      if (pend_cnt_q == 2'd0) begin
        g_b0  = din;
        g_b1  = 8'd0;
        g_cnt = 2'd1;
      end else begin
        g_b1  = din;
        g_cnt = 2'd2;
      end
    end
  end

  assign grp_nl   = line_q >= b64_lim_q;
  assign g_chr[0] = b64_chr(g_b0[7:2]);
  assign g_chr[1] = b64_chr({g_b0[1:0], g_b1[7:4]});
  assign g_chr[2] = (g_cnt >= 2'd2) ? b64_chr({g_b1[3:0], g_b2[7:6]}) : CHR_EQ;
  assign g_chr[3] = (g_cnt == 2'd3) ? b64_chr(g_b2[5:0]) : CHR_EQ;

  always_comb begin
    for (int i = 0; i < MAX_CHARS; i++) begin
      res_chr[i] = CHR_NL;
    end
    res_cnt      = '0;
    upd_line     = line_q;
    upd_pend_b   = pend_b_q;
    upd_pend_cnt = pend_cnt_q;
    if (mode_q == MODE_QP) begin
      if (qp_over && (din == CHR_NL)) begin
        // newline at the limit goes out bare
        res_cnt  = CNT_W'(1);
        upd_line = 8'd0;
      end else if (qp_over) begin
        res_chr[0] = CHR_EQ;
        for (int i = 0; i < 3; i++) begin
          res_chr[i+2] = piece[i];
        end
        res_cnt  = CNT_W'(2) + CNT_W'(plen);
        upd_line = {6'd0, plen};
      end else begin
        for (int i = 0; i < 3; i++) begin
          res_chr[i] = piece[i];
        end
        res_cnt  = CNT_W'(plen);
        upd_line = sat_add(line_q, {1'b0, plen});
      end
      if (s_axis_tlast_i) begin
        upd_line     = 8'd0;
        upd_pend_b   = '0;
        upd_pend_cnt = '0;
      end
    end else begin
      if (pend_cnt_q == 2'd0) begin
        upd_pend_b   = {din, 8'd0};
        upd_pend_cnt = 2'd1;
      end else if (pend_cnt_q == 2'd1) begin
        upd_pend_b   = {pend_b_q[15:8], din};
        upd_pend_cnt = 2'd2;
      end else begin
        upd_pend_b   = '0;
        upd_pend_cnt = '0;
      end
      if (grp_en) begin
        if (grp_nl) begin
          for (int i = 0; i < 4; i++) begin
            res_chr[i+1] = g_chr[i];
          end
          res_cnt  = CNT_W'(5);
          upd_line = 8'd4;
        end else begin
          for (int i = 0; i < 4; i++) begin
            res_chr[i] = g_chr[i];
          end
          res_cnt  = CNT_W'(4);
          upd_line = sat_add(line_q, 3'd4);
        end
      end
      // last line is never empty after a group, so it always gets its newline
      if (s_axis_tlast_i) begin
        res_cnt      = res_cnt + CNT_W'(1);
        upd_line     = 8'd0;
        upd_pend_b   = '0;
        upd_pend_cnt = '0;
      end
    end
  end

  always_comb begin
    mode_d     = mode_q;
    qp_lim_d   = qp_lim_q;
    b64_lim_d  = b64_lim_q;
    pend_b_d   = pend_b_q;
    pend_cnt_d = pend_cnt_q;
    line_d     = line_q;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MODE: begin
          mode_d     = pwdata[0];
          pend_b_d   = '0;
          pend_cnt_d = '0;
          line_d     = '0;
        end
        REG_QP_LIMIT:  qp_lim_d  = pwdata[7:0];
        REG_B64_LIMIT: b64_lim_d = pwdata[7:0];
        default: ;
      endcase
    end else if (in_acc) begin
      pend_b_d   = upd_pend_b;
      pend_cnt_d = upd_pend_cnt;
      line_d     = upd_line;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_CHARS; i++) begin
      chr_d[i] = chr_q[i];
    end
    cnt_d = cnt_q;
    if (in_acc) begin
      for (int i = 0; i < MAX_CHARS; i++) begin
        chr_d[i] = res_chr[i];
      end
      cnt_d = res_cnt;
    end else if (out_acc) begin
      for (int i = 0; i < MAX_CHARS - 1; i++) begin
        chr_d[i] = chr_q[i+1];
      end
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_QP;
      qp_lim_q   <= QP_LIMIT_RST;
      b64_lim_q  <= B64_LIMIT_RST;
      pend_b_q   <= '0;
      pend_cnt_q <= '0;
      line_q     <= '0;
      cnt_q      <= '0;
    end else begin
      mode_q     <= mode_d;
      qp_lim_q   <= qp_lim_d;
      b64_lim_q  <= b64_lim_d;
      pend_b_q   <= pend_b_d;
      pend_cnt_q <= pend_cnt_d;
      line_q     <= line_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_CHARS; i++) begin
      chr_q[i] <= chr_d[i];
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_CHARS))
    else $error("output character count out of range");

  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q != 2'd3)
    else $error("base64 group holds three bytes");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i) |=> (pend_cnt_q == 2'd0) && (line_q == 8'd0))
    else $error("body end did not clear line and group state");

  a_b64_mid_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (mode_q == MODE_B64) && (pend_cnt_q != 2'd2) && !s_axis_tlast_i)
      |=> (cnt_q == '0))
    else $error("base64 byte inside a group produced characters");
`endif

endmodule

// ===== sim/mbte_stream_checker.sv =====
`timescale 1ns / 1ps

module mbte_stream_checker
  import mbte_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic [7:0]        s_axis_tdata_i,   // data_byte[7:0]
  input  logic              s_axis_tlast_i,
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  logic [7:0]        m_axis_tdata_i,   // out_char[7:0]
  input  logic              m_axis_tlast_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int                mismatch_count_o,
  output int                chars_owed_o,
  output int                chars_checked_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  string hex_digits   = "0123456789ABCDEF";
  string b64_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic       enc_mode;
  logic [7:0] qp_limit;
  logic [7:0] b64_limit;
  logic [15:0] held_bytes;
  logic [1:0]  held_count;
  logic [7:0]  col_fill;

  enc_char_t  encoded_q[$];
  logic [7:0] fresh_chars[$];
  int         mismatches;
  int         checked;

  task automatic clear_line();
    held_bytes = '0;
    held_count = '0;
    col_fill   = '0;
  endtask

  task automatic grow_line(input int k);
    int s;
    s = int'(col_fill) + k;
    col_fill = (s > 255) ? 8'd255 : s[7:0];
  endtask

  task automatic qp_piece(input logic [7:0] d);
    logic esc;
    int   plen;
    esc  = (d < CHR_PRINT_LO) || (d == CHR_EQ) || (d > CHR_PRINT_HI);
    plen = esc ? 3 : 1;
    if (int'(col_fill) + plen > int'(qp_limit)) begin
      col_fill = '0;
      // a newline at the limit replaces its own escape
      if (d == CHR_NL) begin
        fresh_chars.push_back(CHR_NL);
        return;
      end
      fresh_chars.push_back(CHR_EQ);
      fresh_chars.push_back(CHR_NL);
    end
    if (esc) begin
      fresh_chars.push_back(CHR_EQ);
      fresh_chars.push_back(hex_digits[d[7:4]]);
      fresh_chars.push_back(hex_digits[d[3:0]]);
    end else begin
      fresh_chars.push_back(d);
    end
    grow_line(plen);
  endtask

  task automatic b64_quad(input logic [7:0] b0, input logic [7:0] b1,
                          input logic [7:0] b2, input int cnt);
    if (col_fill >= b64_limit) begin
      fresh_chars.push_back(CHR_NL);
      col_fill = '0;
    end
    fresh_chars.push_back(b64_alphabet[b0[7:2]]);
    fresh_chars.push_back(b64_alphabet[{b0[1:0], b1[7:4]}]);
    fresh_chars.push_back((cnt >= 2) ? b64_alphabet[{b1[3:0], b2[7:6]}] : CHR_EQ);
    fresh_chars.push_back((cnt >= 3) ? b64_alphabet[b2[5:0]] : CHR_EQ);
    grow_line(4);
  endtask

  task automatic encode_body_byte(input logic [7:0] d, input logic last);
    fresh_chars.delete();
    if (enc_mode == MODE_QP) begin
      qp_piece(d);
      if (last) clear_line();
    end else begin
      if (held_count >= 2'd2) begin
        b64_quad(held_bytes[15:8], held_bytes[7:0], d, 3);
        held_bytes = '0;
        held_count = '0;
      end else begin
        if (held_count == 2'd0) held_bytes = {d, 8'h00};
        else held_bytes[7:0] = d;
        held_count = held_count + 2'd1;
      end
      if (last) begin
        // partial group gets padded, missing bytes read as zero
        if (held_count != 2'd0) begin
          b64_quad(held_bytes[15:8], (held_count >= 2'd2) ? held_bytes[7:0] : 8'h00,
                   8'h00, int'(held_count));
        end
        if (col_fill != 8'd0) fresh_chars.push_back(CHR_NL);
        clear_line();
      end
    end
    foreach (fresh_chars[i]) begin
      encoded_q.push_back('{ch: fresh_chars[i], last: (i == fresh_chars.size() - 1)});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    enc_char_t want;
    if (!rst_ni) begin
      enc_mode   = MODE_QP;
      qp_limit   = QP_LIMIT_RST;
      b64_limit  = B64_LIMIT_RST;
      clear_line();
      encoded_q.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MODE: begin
            enc_mode = pwdata[0];
            clear_line();
          end
          REG_QP_LIMIT:  qp_limit  = pwdata[7:0];
          REG_B64_LIMIT: b64_limit = pwdata[7:0];
          default: ;
        endcase
      end
      // an output item at this edge always belongs to an earlier input item
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        checked++;
        if (encoded_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected char: expected none, got %02h last %b",
                   $time, m_axis_tdata_i, m_axis_tlast_i);
        end else begin
          want = encoded_q.pop_front();
          if (m_axis_tdata_i !== want.ch) begin
            mismatches++;
            $display("%0t: char mismatch: expected %02h, got %02h",
                     $time, want.ch, m_axis_tdata_i);
          end
          if (m_axis_tlast_i !== want.last) begin
            mismatches++;
            $display("%0t: tlast mismatch: expected %b, got %b",
                     $time, want.last, m_axis_tlast_i);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        encode_body_byte(s_axis_tdata_i, s_axis_tlast_i);
      end
    end
    mismatch_count_o <= mismatches;
    chars_owed_o     <= encoded_q.size();
    chars_checked_o  <= checked;
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import mbte_pkg::*;

  localparam int BODY_BYTES  = 160;
  localparam int CYCLE_LIMIT = 300000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;
  logic              m_axis_tlast;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatch_count;
  int chars_owed;
  int chars_checked;

  int cycles = 0;
  int burst_left = 0;
  int stall_style = 0;
  int stall_left = 0;
  int bytes_sent = 0;
  int bodies = 0;
  int settings_used = 0;
  logic [7:0] body_bytes[$];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  mime_body_transfer_encoder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  mbte_stream_checker stream_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_axis_tvalid),
    .s_axis_tready_i  (s_axis_tready),
    .s_axis_tdata_i   (s_axis_tdata),
    .s_axis_tlast_i   (s_axis_tlast),
    .m_axis_tvalid_i  (m_axis_tvalid),
    .m_axis_tready_i  (m_axis_tready),
    .m_axis_tdata_i   (m_axis_tdata),
    .m_axis_tlast_i   (m_axis_tlast),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatch_count_o (mismatch_count),
    .chars_owed_o     (chars_owed),
    .chars_checked_o  (chars_checked)
  );

  // receiver: free-running, coin-flip, periodic and rare-stall stretches
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(16, 80);
    end
    stall_left--;
    case (stall_style)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (cycles % 5) > 1;
      default: m_axis_tready <= $urandom_range(0, 9) != 0;
    endcase
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d chars still owed", cycles, chars_owed);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] d, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_body();
    foreach (body_bytes[i]) push_byte(body_bytes[i], i == body_bytes.size() - 1);
    bodies++;
  endtask

  // drain all owed chars, then leave room for a byte that made none
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (chars_owed != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic m, input logic [7:0] qp_lim,
                               input logic [7:0] b64_lim);
    wait_idle();
    reg_write(REG_MODE, {7'd0, m});
    reg_write(REG_QP_LIMIT, qp_lim);
    reg_write(REG_B64_LIMIT, b64_lim);
    settings_used++;
  endtask

  function automatic logic [7:0] body_byte();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: return 8'($urandom_range(33, 126));
      3:       return CHR_NL;
      4:       return CHR_EQ;
      5: begin
        pick = $urandom_range(0, 3);
        return (pick == 0) ? 8'd32 : (pick == 1) ? 8'd33 : (pick == 2) ? 8'd126 : 8'd127;
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int len;
    int pick;
    logic [7:0] qp_lim;
    logic [7:0] b64_lim;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // quoted-printable at reset limits: escape boundaries and plain bytes
    body_bytes = '{8'd0, 8'd10, 8'd33, 8'd61, 8'd126, 8'd127, 8'd255};
    send_body();
    // tight line: soft break before an escape, bare newline at the limit
    apply_setting(MODE_QP, 8'd4, B64_LIMIT_RST);
    body_bytes = '{8'd97, 8'd98, 8'd61, 8'd10, 8'd122};
    send_body();
    // base64: both paddings, the '+' and '/' chars, line break at a short limit
    apply_setting(MODE_B64, QP_LIMIT_RST, 8'd4);
    body_bytes = '{8'hFF};
    send_body();
    body_bytes = '{8'h00, 8'hFF};
    send_body();
    body_bytes = '{8'hFB, 8'hFF, 8'hBF, 8'h41};
    send_body();

    while (bytes_sent < BODY_BYTES) begin
      pick    = $urandom_range(0, 3);
      qp_lim  = (pick == 0) ? 8'd4 : (pick == 1) ? 8'd255 : 8'($urandom_range(4, 255));
      pick    = $urandom_range(0, 3);
      b64_lim = (pick == 0) ? 8'd4 : (pick == 1) ? 8'd252 : 8'($urandom_range(4, 252));
      apply_setting(1'($urandom_range(0, 1)), qp_lim, b64_lim);
      repeat ($urandom_range(1, 3)) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        if (len > BODY_BYTES - bytes_sent) len = BODY_BYTES - bytes_sent;
        if (len > 0) begin
          body_bytes.delete();
          repeat (len) body_bytes.push_back(body_byte());
          send_body();
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("sent %0d body bytes in %0d bodies under %0d register settings",
             bytes_sent, bodies, settings_used);
    $display("compared %0d encoded chars, %0d mismatches, %0d chars never seen",
             chars_checked, mismatch_count, chars_owed);
    if (mismatch_count == 0 && chars_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mbte_pkg.sv
rtl/mime_body_transfer_encoder_core.sv
sim/mbte_stream_checker.sv
sim/testbench.sv
